>>> hw/rtl/bm25_pkg.sv
// Package for the BM25 top-K ranker: payload structs, widths, constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bm25_pkg;
    localparam int TOP_K = 10;
    localparam int IDX_W = $clog2(TOP_K);
    localparam int CNT_W = $clog2(TOP_K + 1);
    localparam int NUM_W = 64;
    localparam int DEN_W = 44;
    localparam logic OP_TERM  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic        opcode;
        logic [31:0] document_id;
        logic [15:0] term_frequency;
        logic [15:0] inverse_doc_freq;
        logic [23:0] document_length;
        logic        final_term;
    } t_in_item;

    typedef struct packed {
        logic [31:0] ranked_doc_id;
        logic [31:0] ranked_score;
        logic        end_of_list;
        logic        list_empty;
    } t_out_item;

    // Front-to-back command: a prepared division or a flush.
    typedef struct packed {
        logic             flush;
        logic             last;
        logic [31:0]      doc;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_cmd;
endpackage
`default_nettype wire

>>> hw/rtl/bm25_front.sv
// Front end: accepts input transactions, forms the BM25 dividend and divisor.
// Depends on bm25_pkg. Multiplies are registered in two stages.
`timescale 1ns / 1ps
`default_nettype none
module bm25_front import bm25_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire t_in_item    i_item,
    input  wire logic [23:0] i_avg,
    output logic             o_cmd_valid,
    input  wire logic        i_cmd_ready,
    output t_cmd             o_cmd
);
    logic        r_s1_v, r_s2_v;
    t_in_item    r_s1;
    logic [39:0] r_tfavg;   // tf*avg
    logic [27:0] r_avg3;
    logic [27:0] r_len9;
    t_cmd        r_s2;
    logic        s2_free;

    assign s2_free = !r_s2_v || i_cmd_ready;
    assign o_full  = r_s1_v && !s2_free;
    assign o_cmd_valid = r_s2_v;
    assign o_cmd = r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
        end else begin
            if (s2_free) r_s2_v <= r_s1_v;
            if (!o_full) r_s1_v <= i_push;
        end
        if (!o_full && i_push) begin
            r_s1    <= i_item;
            r_tfavg <= 40'(i_item.term_frequency) * 40'(i_avg);
            r_avg3  <= 28'(i_avg) * 28'd3;
            r_len9  <= 28'(i_item.document_length) * 28'd9;
        end
        if (s2_free && r_s1_v) begin
            r_s2.flush <= (r_s1.opcode == OP_FLUSH);
            r_s2.last  <= r_s1.final_term;
            r_s2.doc   <= r_s1.document_id;
            // 20*idf*tf*avg fits 40+16+5 = 61 bits
            r_s2.num   <= NUM_W'(r_tfavg) * NUM_W'(r_s1.inverse_doc_freq) * NUM_W'(20);
            r_s2.den   <= DEN_W'({r_tfavg, 3'b000}) + DEN_W'(r_avg3) + DEN_W'(r_len9);
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/bm25_cmdq.sv
// Two-entry command queue between front and back ends.
// Depends on bm25_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bm25_cmdq import bm25_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_cmd      o_cmd
);
    t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic wr, rd;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rp];
    assign wr = i_valid && o_ready;
    assign rd = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(wr) - 2'(rd);
        end
        if (wr) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

>>> hw/rtl/bm25_back.sv
// Back end: serial divider, score accumulator, top-K table, flush emitter.
// Depends on bm25_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bm25_back import bm25_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  wire t_cmd i_cmd,
    output logic      o_empty,
    input  wire logic i_pop,
    output t_out_item o_item
);
    localparam logic [2:0] ST_IDLE = 3'd0, ST_DIV = 3'd1, ST_ACC = 3'd2,
                           ST_SCAN = 3'd3, ST_EMIT = 3'd4;

    logic [2:0]       r_st;
    logic [NUM_W-1:0] r_q;       // dividend shifting into quotient
    logic [DEN_W:0]   r_rem;
    logic [DEN_W-1:0] r_den;
    logic [6:0]       r_bit;
    logic             r_last;
    logic [31:0]      r_doc;
    logic [31:0]      r_acc;
    logic [31:0]      r_new;
    logic [CNT_W-1:0] r_cnt;
    logic [IDX_W-1:0] r_idx, r_min_idx;
    logic [31:0]      r_min;
    logic [31:0]      r_tdoc [TOP_K];
    logic [31:0]      r_tscore [TOP_K];
    logic             r_ov_v;
    t_out_item        r_ov;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [32:0]      sum;
    logic [31:0]      qsat;

    assign rem_sh = {r_rem[DEN_W-1:0], r_q[NUM_W-1]};
    assign ge     = rem_sh >= {1'b0, r_den};
    assign qsat   = (r_q[NUM_W-1:32] != '0) ? 32'hFFFF_FFFF : r_q[31:0];
    assign sum    = {1'b0, r_acc} + {1'b0, qsat};
    assign o_cmd_ready = (r_st == ST_IDLE);
    assign o_empty = !r_ov_v;
    assign o_item  = r_ov;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE; r_acc <= '0; r_cnt <= '0; r_ov_v <= 1'b0;
        end else begin
            // the emitter refills the result register itself
            if (i_pop && r_ov_v && r_st != ST_EMIT) r_ov_v <= 1'b0;
            case (r_st)
                ST_IDLE: begin
                    if (i_cmd_valid) begin
                        if (i_cmd.flush) begin
                            r_idx <= '0;
                            r_st  <= ST_EMIT;
                        end else begin
                            r_q   <= i_cmd.num;
                            r_den <= i_cmd.den;
                            r_rem <= '0;
                            r_bit <= 7'd0;
                            r_last <= i_cmd.last;
                            r_doc <= i_cmd.doc;
                            r_st  <= ST_DIV;
                        end
                    end
                end
                ST_DIV: begin
                    // restoring division, one quotient bit per cycle
                    r_rem <= ge ? rem_sh - {1'b0, r_den} : rem_sh;
                    r_q   <= {r_q[NUM_W-2:0], ge};
                    r_bit <= r_bit + 7'd1;
                    if (r_bit == 7'(NUM_W - 1)) r_st <= ST_ACC;
                end
                ST_ACC: begin
                    // zero divisor gives all-ones quotient; dividend is zero then
                    if (r_den == '0) r_q <= '0;
                    if (r_den == '0) begin
                        // accumulator unchanged by a zero contribution
                        if (r_last) begin
                            r_new <= r_acc; r_acc <= '0;
                        end
                    end else if (r_last) begin
                        r_new <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        r_acc <= '0;
                    end else begin
                        r_acc <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    end
                    if (!r_last) r_st <= ST_IDLE;
                    else if (r_cnt < CNT_W'(TOP_K)) begin
                        r_st <= ST_IDLE;
                    end else begin
                        r_st <= ST_SCAN;
                        r_idx <= IDX_W'(1);
                        r_min_idx <= '0;
                        r_min <= r_tscore[0];
                    end
                    if (r_last && r_cnt < CNT_W'(TOP_K)) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                end
                ST_SCAN: begin
                    if (r_idx == IDX_W'(TOP_K)) begin
                        if (r_new > r_min) begin
                            r_tdoc[r_min_idx]   <= r_doc;
                            r_tscore[r_min_idx] <= r_new;
                        end
                        r_st <= ST_IDLE;
                    end else begin
                        if (r_tscore[r_idx] < r_min) begin
                            r_min <= r_tscore[r_idx];
                            r_min_idx <= r_idx;
                        end
                        r_idx <= r_idx + IDX_W'(1);
                    end
                end
                ST_EMIT: begin
                    if (!r_ov_v || i_pop) begin
                        r_ov_v <= 1'b1;
                        if (r_cnt == '0) begin
                            r_ov <= '{32'd0, 32'd0, 1'b1, 1'b1};
                            r_st <= ST_IDLE;
                        end else begin
                            r_ov <= '{r_tdoc[r_idx], r_tscore[r_idx],
                                      (CNT_W'(r_idx) + CNT_W'(1) == r_cnt), 1'b0};
                            r_idx <= r_idx + IDX_W'(1);
                            if (CNT_W'(r_idx) + CNT_W'(1) == r_cnt) begin
                                r_cnt <= '0;
                                r_st  <= ST_IDLE;
                            end
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
        if (r_st == ST_ACC && r_last && r_cnt < CNT_W'(TOP_K)) begin
            r_tdoc[r_cnt[IDX_W-1:0]] <= r_doc;
            r_tscore[r_cnt[IDX_W-1:0]] <= (r_den == '0) ? r_acc
                : (sum[32] ? 32'hFFFF_FFFF : sum[31:0]);
        end
    end
endmodule
`default_nettype wire

>>> hw/rtl/bm25_top_k_ranker.sv
// Top level of the BM25 top-K ranker: front end, command queue, back end.
// Depends on bm25_pkg, bm25_front, bm25_cmdq, bm25_back.
//
// Usage:
//  - Input channel: queue style, push/full. A transaction is either a term
//    (opcode 0) or a flush (opcode 1).
//  - Result channel: queue style, empty/pop. Results appear only on a flush:
//    one per filled table slot in slot order, end_of_list on the last, or a single
//    list_empty result when the table holds nothing.
//  - Config channel: valid/ready write of average_doc_length; always ready.
//    Write only while the block is idle.
//  - Datapath: two front-end stages, then the back end divides one quotient
//    bit per cycle and accumulates the result in a separate state. A final
//    term on a full table adds a scan of the table for its lowest score. The
//    back end takes one term at a time and is bounded by the serial divider.
//  - A flush emits one result per cycle while the receiver pops.
//  - The command queue lets the front accept while the back divides.
//  - Reset (synchronous, active low) clears accumulator, entry count and
//    queues; average_doc_length returns to 1. Table contents are not cleared.
//  - A stalled receiver holds the result register and stalls the emitter.
`timescale 1ns / 1ps
`default_nettype none
module bm25_top_k_ranker import bm25_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire t_in_item    i_item,
    output logic             empty,
    input  wire logic        pop,
    output t_out_item        o_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [23:0] i_cfg_data
);
    logic [23:0] r_avg;
    logic f_v, f_r, q_v, q_r;
    t_cmd f_c, q_c;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_avg <= 24'd1;
        else if (i_cfg_valid) r_avg <= i_cfg_data;
    end

    bm25_front u_front (.i_clk, .i_rst_n, .i_push(push), .o_full(full), .i_item,
        .i_avg(r_avg), .o_cmd_valid(f_v), .i_cmd_ready(f_r), .o_cmd(f_c));
    bm25_cmdq u_q (.i_clk, .i_rst_n, .i_valid(f_v), .o_ready(f_r), .i_cmd(f_c),
        .o_valid(q_v), .i_ready(q_r), .o_cmd(q_c));
    bm25_back u_back (.i_clk, .i_rst_n, .i_cmd_valid(q_v), .o_cmd_ready(q_r),
        .i_cmd(q_c), .o_empty(empty), .i_pop(pop), .o_item);
endmodule
`default_nettype wire

>>> hw/rtl/bm25_checker.sv
// Port-level checker for the BM25 top-K ranker, bound to the top level.
// Depends on bm25_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bm25_checker import bm25_pkg::*; (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      empty,
    input wire logic      pop,
    input wire t_out_item o_item
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_item))) else $error("result dropped");
    a_emptyfl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.list_empty) |-> o_item.end_of_list) else $error("bad empty");
    a_emptyz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_item.list_empty) |-> (o_item.ranked_doc_id == 32'd0))
        else $error("bad empty fields");
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> empty) else $error("reset");
endmodule
bind bm25_top_k_ranker bm25_checker u_chk (.i_clk, .i_rst_n, .empty, .pop, .o_item);
`default_nettype wire
